FILE: rtl/camera_point_undistort_to_plane_defines.svh
// Assertion macros used by the checker file of the undistortion block.
`ifndef CAMERA_POINT_UNDISTORT_TO_PLANE_DEFINES_SVH
`define CAMERA_POINT_UNDISTORT_TO_PLANE_DEFINES_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define CPUP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication on the following cycle, disabled while reset is asserted.
`define CPUP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Plain check at every clock edge, reset included.
`define CPUP_ASSERT_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

FILE: rtl/cpup_pkg.sv
// Package with the payload types and fixed constants of the undistortion block.
`timescale 1ns / 1ps

package cpup_pkg;

    typedef struct packed {
        logic [8:0] pixel_x;
        logic [8:0] pixel_y;
    } cpup_in_t;

    typedef struct packed {
        logic signed [19:0] world_x;
        logic signed [19:0] world_y;
        logic               out_of_range;
    } cpup_out_t;

    // Per-transaction control bits that travel beside the arithmetic.
    typedef struct packed {
        logic valid;
        logic bad;
        logic flag;
        logic sgn_x;
        logic sgn_y;
    } cpup_side_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_DEPTH = 3'd7;

    localparam logic [15:0] FOCAL_RESET = 16'd16;

    // Normalized coordinate magnitude, Q16, and the divisor width after the radial stage.
    localparam int XN_W  = 32;
    localparam int DEN_W = 38;
    localparam int U_W   = XN_W + 16;

    localparam logic [XN_W-1:0]  SQ_LIMIT = 32'd1048576;
    localparam logic [26:0]      R2_CAP   = 27'd16777216;
    localparam logic signed [37:0] WORLD_MAX = 38'sd524287;
    localparam logic signed [37:0] WORLD_MIN = -38'sd524288;

endpackage

FILE: rtl/cpup_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps

module cpup_div #(
    parameter int NW = 32,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    logic [NW-1:0] num_reg [1:NW-1];
    logic [DW-1:0] den_reg [1:NW-1];
    logic [DW-1:0] rem_reg [1:NW-1];
    logic [NW-1:0] quo_reg [1:NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [NW-1:0] s_num;
        logic [DW-1:0] s_den;
        logic [DW-1:0] s_rem;
        logic [NW-1:0] s_quo;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign s_num = num;
            assign s_den = den;
            assign s_rem = '0;
            assign s_quo = '0;
        end
        else
        begin : g_mid
            assign s_num = num_reg[k];
            assign s_den = den_reg[k];
            assign s_rem = rem_reg[k];
            assign s_quo = quo_reg[k];
        end

        // Bring down the next dividend bit and try one subtraction.
        assign trial = {s_rem, s_num[NW-1-k]};
        assign diff  = trial - {1'b0, s_den};
        assign ge    = (trial >= {1'b0, s_den});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k+1] <= {s_quo[NW-2:0], ge};
            end
        end

        if (k < NW - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[k+1] <= s_num;
                    den_reg[k+1] <= s_den;
                    rem_reg[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                end
            end
        end
    end

    assign quo = quo_reg[NW];

endmodule

FILE: rtl/cpup_dly.sv
// Delay line that carries control bits beside a divider pipeline.
`timescale 1ns / 1ps

module cpup_dly #(
    parameter int W = 5,
    parameter int N = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [0:N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[N-1];

endmodule

FILE: rtl/camera_point_undistort_to_plane.sv
// Top level of the radial undistortion block: pixel pair in, world position out.
`timescale 1ns / 1ps

// Usage.
// The input channel takes one raw pixel pair per transaction (in_valid, in_stall,
// in_data). The output channel delivers one world position per input transaction
// (out_valid, out_stall, out_data), in input order, with the out_of_range flag.
// Configuration registers are written through cfg_valid, cfg_ready, cfg_index and
// cfg_data; cfg_ready is always high, and indexes beyond the list are ignored.
// Write configuration only while no transaction is in flight.
// From acceptance to out_valid the path runs through one input stage, a 32-stage
// divider for the focal normalization, five stages for the radius polynomial, a
// 48-stage divider for the radial correction, and two stages for depth scaling
// and saturation. Throughput is one transaction per cycle while no result is held
// by the receiver; the two pipelined dividers set the depth, not the rate.
// When the receiver stalls a valid result, the whole pipeline holds and in_stall
// rises in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits and loads the registers with their reset values
// (focal length 16, all others zero). The block accepts items right after reset.

module camera_point_undistort_to_plane #(
    parameter int IMAGE_SCALE = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  cpup_pkg::cpup_in_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output cpup_pkg::cpup_out_t                  out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cpup_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cpup_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SIDE_W = $bits(cpup_pkg::cpup_side_t);

    // Configuration registers.
    logic [15:0]        center_x_reg;
    logic [15:0]        center_y_reg;
    logic [15:0]        focal_len_reg;
    logic signed [19:0] radial_k1_reg;
    logic signed [19:0] radial_k2_reg;
    logic signed [15:0] offset_x_reg;
    logic signed [15:0] offset_y_reg;
    logic [15:0]        plane_depth_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            focal_len_reg   <= cpup_pkg::FOCAL_RESET;
            radial_k1_reg   <= '0;
            radial_k2_reg   <= '0;
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
            plane_depth_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cpup_pkg::REG_CENTER_X:    center_x_reg    <= cfg_data[15:0];
                cpup_pkg::REG_CENTER_Y:    center_y_reg    <= cfg_data[15:0];
                cpup_pkg::REG_FOCAL_LEN:   focal_len_reg   <= cfg_data[15:0];
                cpup_pkg::REG_RADIAL_K1:   radial_k1_reg   <= $signed(cfg_data[19:0]);
                cpup_pkg::REG_RADIAL_K2:   radial_k2_reg   <= $signed(cfg_data[19:0]);
                cpup_pkg::REG_OFFSET_X:    offset_x_reg    <= $signed(cfg_data[15:0]);
                cpup_pkg::REG_OFFSET_Y:    offset_y_reg    <= $signed(cfg_data[15:0]);
                cpup_pkg::REG_PLANE_DEPTH: plane_depth_reg <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // The pipeline moves as one unless a finished result is held by the receiver.
    logic en;
    logic out_valid_reg;
    cpup_pkg::cpup_out_t out_data_reg;

    assign en        = !out_valid_reg || !out_stall;
    assign in_stall  = !en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Stage A: scale the pixel, subtract the centre, split into sign and magnitude.
    logic [16:0]        scaled_x;
    logic [16:0]        scaled_y;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic [17:0]        abs_x;
    logic [17:0]        abs_y;

    assign scaled_x = 17'(in_data.pixel_x) * 17'(IMAGE_SCALE * 16);
    assign scaled_y = 17'(in_data.pixel_y) * 17'(IMAGE_SCALE * 16);
    assign dx       = $signed({1'b0, scaled_x}) - $signed({2'b00, center_x_reg});
    assign dy       = $signed({1'b0, scaled_y}) - $signed({2'b00, center_y_reg});
    assign abs_x    = dx[17] ? 18'(-dx) : 18'(dx);
    assign abs_y    = dy[17] ? 18'(-dy) : 18'(dy);

    cpup_pkg::cpup_side_t side_a_next;
    cpup_pkg::cpup_side_t side_a_reg;
    logic [15:0]          mag_x_a_reg;
    logic [15:0]          mag_y_a_reg;

    always_comb
    begin
        side_a_next       = '0;
        side_a_next.valid = in_valid;
        side_a_next.bad   = (focal_len_reg == 16'd0);
        side_a_next.flag  = 1'b0;
        side_a_next.sgn_x = dx[17];
        side_a_next.sgn_y = dy[17];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_a_reg <= '0;
        end
        else if (en)
        begin
            side_a_reg <= side_a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_x_a_reg <= abs_x[15:0];
            mag_y_a_reg <= abs_y[15:0];
        end
    end

    // Focal normalization: |xn| = |dx| * 65536 / focal_len.
    logic [cpup_pkg::XN_W-1:0] xn_mag;
    logic [cpup_pkg::XN_W-1:0] yn_mag;
    logic [SIDE_W-1:0]         side_b_dly;

    cpup_div #(.NW(cpup_pkg::XN_W), .DW(16)) u_div_xn (
        .clk (clk),
        .en  (en),
        .num ({mag_x_a_reg, 16'd0}),
        .den (focal_len_reg),
        .quo (xn_mag)
    );

    cpup_div #(.NW(cpup_pkg::XN_W), .DW(16)) u_div_yn (
        .clk (clk),
        .en  (en),
        .num ({mag_y_a_reg, 16'd0}),
        .den (focal_len_reg),
        .quo (yn_mag)
    );

    cpup_dly #(.W(SIDE_W), .N(cpup_pkg::XN_W)) u_dly_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (side_a_reg),
        .q     (side_b_dly)
    );

    // Stage B: squares of the normalized magnitudes. Anything above 2^20 caps r2 anyway.
    cpup_pkg::cpup_side_t      side_b_reg;
    logic [cpup_pkg::XN_W-1:0] ax_b_reg;
    logic [cpup_pkg::XN_W-1:0] ay_b_reg;
    logic                      big_b_reg;
    logic [41:0]               sq_x_b_reg;
    logic [41:0]               sq_y_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_b_reg <= '0;
        end
        else if (en)
        begin
            side_b_reg <= side_b_dly;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_b_reg   <= xn_mag;
            ay_b_reg   <= yn_mag;
            big_b_reg  <= (xn_mag > cpup_pkg::SQ_LIMIT) || (yn_mag > cpup_pkg::SQ_LIMIT);
            sq_x_b_reg <= 42'(xn_mag[20:0]) * 42'(xn_mag[20:0]);
            sq_y_b_reg <= 42'(yn_mag[20:0]) * 42'(yn_mag[20:0]);
        end
    end

    // Stage C: r2 with its cap.
    logic [26:0] r2_sum;
    logic        r2_over;

    assign r2_sum  = {1'b0, sq_x_b_reg[41:16]} + {1'b0, sq_y_b_reg[41:16]};
    assign r2_over = big_b_reg || (r2_sum > cpup_pkg::R2_CAP);

    cpup_pkg::cpup_side_t      side_c_next;
    cpup_pkg::cpup_side_t      side_c_reg;
    logic [cpup_pkg::XN_W-1:0] ax_c_reg;
    logic [cpup_pkg::XN_W-1:0] ay_c_reg;
    logic [24:0]               r2_c_reg;

    always_comb
    begin
        side_c_next      = side_b_reg;
        side_c_next.flag = side_b_reg.flag | r2_over;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_c_reg <= '0;
        end
        else if (en)
        begin
            side_c_reg <= side_c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_c_reg <= ax_b_reg;
            ay_c_reg <= ay_b_reg;
            r2_c_reg <= r2_over ? cpup_pkg::R2_CAP[24:0] : r2_sum[24:0];
        end
    end

    // Stage D: r2 squared and k1 * r2.
    cpup_pkg::cpup_side_t      side_d_reg;
    logic [cpup_pkg::XN_W-1:0] ax_d_reg;
    logic [cpup_pkg::XN_W-1:0] ay_d_reg;
    logic [49:0]               r4p_d_reg;
    logic signed [45:0]        k1r2_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_d_reg <= '0;
        end
        else if (en)
        begin
            side_d_reg <= side_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_d_reg   <= ax_c_reg;
            ay_d_reg   <= ay_c_reg;
            r4p_d_reg  <= 50'(r2_c_reg) * 50'(r2_c_reg);
            k1r2_d_reg <= 46'(radial_k1_reg) * 46'($signed({1'b0, r2_c_reg}));
        end
    end

    // Stage E: k2 * r4.
    cpup_pkg::cpup_side_t      side_e_reg;
    logic [cpup_pkg::XN_W-1:0] ax_e_reg;
    logic [cpup_pkg::XN_W-1:0] ay_e_reg;
    logic signed [45:0]        k1r2_e_reg;
    logic signed [54:0]        k2r4_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_e_reg <= '0;
        end
        else if (en)
        begin
            side_e_reg <= side_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_e_reg   <= ax_d_reg;
            ay_e_reg   <= ay_d_reg;
            k1r2_e_reg <= k1r2_d_reg;
            k2r4_e_reg <= 55'(radial_k2_reg) * 55'($signed({1'b0, r4p_d_reg[49:16]}));
        end
    end

    // Stage F: divisor 65536 + (k1*r2 + k2*r4)/65536, truncated toward zero.
    logic signed [55:0] poly_sum;
    logic signed [55:0] poly_adj;
    logic signed [40:0] div_q16;
    logic               div_bad;

    assign poly_sum = 56'(k1r2_e_reg) + 56'(k2r4_e_reg);
    assign poly_adj = poly_sum + (poly_sum[55] ? 56'sd65535 : 56'sd0);
    assign div_q16  = 41'($signed(poly_adj[55:16])) + 41'sd65536;
    assign div_bad  = div_q16[40] || (div_q16 == 41'sd0);

    cpup_pkg::cpup_side_t       side_f_next;
    cpup_pkg::cpup_side_t       side_f_reg;
    logic [cpup_pkg::XN_W-1:0]  ax_f_reg;
    logic [cpup_pkg::XN_W-1:0]  ay_f_reg;
    logic [cpup_pkg::DEN_W-1:0] den_f_reg;

    always_comb
    begin
        side_f_next     = side_e_reg;
        side_f_next.bad = side_e_reg.bad | div_bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_f_reg <= '0;
        end
        else if (en)
        begin
            side_f_reg <= side_f_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_f_reg  <= ax_e_reg;
            ay_f_reg  <= ay_e_reg;
            den_f_reg <= div_q16[cpup_pkg::DEN_W-1:0];
        end
    end

    // Radial correction: |u| = |xn| * 65536 / divisor.
    logic [cpup_pkg::U_W-1:0] ux_mag;
    logic [cpup_pkg::U_W-1:0] uy_mag;
    logic [SIDE_W-1:0]        side_g_dly;

    cpup_div #(.NW(cpup_pkg::U_W), .DW(cpup_pkg::DEN_W)) u_div_ux (
        .clk (clk),
        .en  (en),
        .num ({ax_f_reg, 16'd0}),
        .den (den_f_reg),
        .quo (ux_mag)
    );

    cpup_div #(.NW(cpup_pkg::U_W), .DW(cpup_pkg::DEN_W)) u_div_uy (
        .clk (clk),
        .en  (en),
        .num ({ay_f_reg, 16'd0}),
        .den (den_f_reg),
        .quo (uy_mag)
    );

    cpup_dly #(.W(SIDE_W), .N(cpup_pkg::U_W)) u_dly_corr (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (side_f_reg),
        .q     (side_g_dly)
    );

    // Stage G: depth product. A magnitude of 2^36 or more saturates for any nonzero depth.
    cpup_pkg::cpup_side_t side_g_reg;
    logic                 big_ux_g_reg;
    logic                 big_uy_g_reg;
    logic [51:0]          px_g_reg;
    logic [51:0]          py_g_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_g_reg <= '0;
        end
        else if (en)
        begin
            side_g_reg <= side_g_dly;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big_ux_g_reg <= (|ux_mag[47:36]) && (plane_depth_reg != 16'd0);
            big_uy_g_reg <= (|uy_mag[47:36]) && (plane_depth_reg != 16'd0);
            px_g_reg     <= 52'(ux_mag[35:0]) * 52'(plane_depth_reg);
            py_g_reg     <= 52'(uy_mag[35:0]) * 52'(plane_depth_reg);
        end
    end

    // Stage H: apply the sign, subtract from the offset, saturate.
    logic signed [37:0] qx;
    logic signed [37:0] qy;
    logic signed [37:0] wx;
    logic signed [37:0] wy;
    logic signed [37:0] wx_sat;
    logic signed [37:0] wy_sat;
    logic               sat_x;
    logic               sat_y;

    assign qx = side_g_reg.sgn_x ? -$signed({2'b00, px_g_reg[51:16]})
                                 :  $signed({2'b00, px_g_reg[51:16]});
    assign qy = side_g_reg.sgn_y ? -$signed({2'b00, py_g_reg[51:16]})
                                 :  $signed({2'b00, py_g_reg[51:16]});
    assign wx = 38'(offset_x_reg) - qx;
    assign wy = 38'(offset_y_reg) - qy;

    always_comb
    begin
        sat_x  = 1'b1;
        wx_sat = wx;
        if (big_ux_g_reg)
        begin
            // A negative u moves the point toward the positive limit, and the other way round.
            wx_sat = side_g_reg.sgn_x ? cpup_pkg::WORLD_MAX : cpup_pkg::WORLD_MIN;
        end
        else if (wx > cpup_pkg::WORLD_MAX)
        begin
            wx_sat = cpup_pkg::WORLD_MAX;
        end
        else if (wx < cpup_pkg::WORLD_MIN)
        begin
            wx_sat = cpup_pkg::WORLD_MIN;
        end
        else
        begin
            sat_x = 1'b0;
        end

        sat_y  = 1'b1;
        wy_sat = wy;
        if (big_uy_g_reg)
        begin
            wy_sat = side_g_reg.sgn_y ? cpup_pkg::WORLD_MAX : cpup_pkg::WORLD_MIN;
        end
        else if (wy > cpup_pkg::WORLD_MAX)
        begin
            wy_sat = cpup_pkg::WORLD_MAX;
        end
        else if (wy < cpup_pkg::WORLD_MIN)
        begin
            wy_sat = cpup_pkg::WORLD_MIN;
        end
        else
        begin
            sat_y = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= side_g_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (side_g_reg.bad)
            begin
                // A zero focal length or a non-positive divisor reports the origin.
                out_data_reg.world_x      <= '0;
                out_data_reg.world_y      <= '0;
                out_data_reg.out_of_range <= 1'b1;
            end
            else
            begin
                out_data_reg.world_x      <= wx_sat[19:0];
                out_data_reg.world_y      <= wy_sat[19:0];
                out_data_reg.out_of_range <= side_g_reg.flag | sat_x | sat_y;
            end
        end
    end

endmodule

FILE: rtl/cpup_chk.sv
// Port-level checker for the undistortion block and its bind statement.
`timescale 1ns / 1ps
`include "camera_point_undistort_to_plane_defines.svh"

module cpup_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input cpup_pkg::cpup_in_t              in_data,
    input logic                            out_valid,
    input logic                            out_stall,
    input cpup_pkg::cpup_out_t             out_data,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);

    // A stalled result stays in place with its payload unchanged.
    `CPUP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled output transaction changed")

    // A stalled input transaction stays offered with its payload unchanged.
    `CPUP_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_data), "stalled input transaction changed")

    // The input side only stalls while a result is held by the receiver.
    `CPUP_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a held output transaction")

    // Configuration writes are always taken.
    `CPUP_ASSERT_SAME(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "configuration write refused")

    // No result is shown while reset is applied.
    `CPUP_ASSERT_ALWAYS(a_reset_quiet, clk, rst_n || !out_valid, "output valid during reset")

endmodule

bind camera_point_undistort_to_plane cpup_chk u_cpup_chk (.*);

FILE: verif/tb.sv
// Testbench for the radial undistortion block: directed and random pixel pairs.
`timescale 1ns / 1ps

module tb;

    // Clock, reset and the three channels of the block.
    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    cpup_pkg::cpup_in_t   in_data;
    logic                 out_valid;
    logic                 out_stall;
    cpup_pkg::cpup_out_t  out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [cpup_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cpup_pkg::CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the configuration registers, kept at the block's widths.
    logic [15:0]        sh_center_x;
    logic [15:0]        sh_center_y;
    logic [15:0]        sh_focal;
    logic signed [19:0] sh_k1;
    logic signed [19:0] sh_k2;
    logic signed [15:0] sh_off_x;
    logic signed [15:0] sh_off_y;
    logic [15:0]        sh_depth;

    // World positions still owed by the block, oldest first.
    cpup_pkg::cpup_out_t pending_world[$];

    int errors;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_recv;
    int hold_cycles;

    camera_point_undistort_to_plane dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Safety net: a hung handshake ends the run as a failure.
    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // Saturating clamp to 20-bit signed; sets the flag when it acts.
    function automatic longint clamp_world(input longint v, inout bit flag);
        if (v > 524287)
        begin
            flag = 1'b1;
            return 524287;
        end
        if (v < -524288)
        begin
            flag = 1'b1;
            return -524288;
        end
        return v;
    endfunction

    // Predict the world position of one pixel pair under the shadow registers.
    // Every division truncates toward zero, which SystemVerilog division does too.
    function automatic cpup_pkg::cpup_out_t project_pixel(input cpup_pkg::cpup_in_t pix);
        cpup_pkg::cpup_out_t res;
        longint xn, yn, r2, r4, den, ux, uy, wx, wy;
        longint ucap;
        longint unsigned ax, ay, s;
        bit flag;
        flag = 1'b0;
        ucap = 64'sd1 <<< 46;
        res = '0;
        res.out_of_range = 1'b1;
        // A zero focal length counts as a non-positive divisor.
        if (sh_focal == 0)
            return res;
        xn = (longint'(pix.pixel_x) * 32 - longint'(sh_center_x)) * 65536 / longint'(sh_focal);
        yn = (longint'(pix.pixel_y) * 32 - longint'(sh_center_y)) * 65536 / longint'(sh_focal);
        ax = (xn < 0) ? -xn : xn;
        ay = (yn < 0) ? -yn : yn;
        s = (ax * ax) / 65536 + (ay * ay) / 65536;
        // A large squared radius is capped at 256.0 and flagged.
        if (s > (64'd1 << 24))
        begin
            s = 64'd1 << 24;
            flag = 1'b1;
        end
        r2 = s;
        r4 = r2 * r2 / 65536;
        den = 65536 + (longint'(sh_k1) * r2 + longint'(sh_k2) * r4) / 65536;
        if (den <= 0)
            return res;
        ux = xn * 65536 / den;
        uy = yn * 65536 / den;
        if (ux > ucap) ux = ucap;
        if (ux < -ucap) ux = -ucap;
        if (uy > ucap) uy = ucap;
        if (uy < -ucap) uy = -ucap;
        wx = clamp_world(longint'(sh_off_x) - ux * longint'(sh_depth) / 65536, flag);
        wy = clamp_world(longint'(sh_off_y) - uy * longint'(sh_depth) / 65536, flag);
        res.world_x = wx[19:0];
        res.world_y = wy[19:0];
        res.out_of_range = flag;
        return res;
    endfunction

    // Write one register and mirror it into the shadow copy. The write
    // strobe stays up for a following write; load_camera drops it.
    // Unknown indexes cannot occur: the index field is exactly three bits wide.
    task automatic write_reg(input logic [cpup_pkg::CFG_IDX_W-1:0] idx,
                             input logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        case (idx)
            cpup_pkg::REG_CENTER_X:    sh_center_x = val[15:0];
            cpup_pkg::REG_CENTER_Y:    sh_center_y = val[15:0];
            cpup_pkg::REG_FOCAL_LEN:   sh_focal    = val[15:0];
            cpup_pkg::REG_RADIAL_K1:   sh_k1       = val;
            cpup_pkg::REG_RADIAL_K2:   sh_k2       = val;
            cpup_pkg::REG_OFFSET_X:    sh_off_x    = val[15:0];
            cpup_pkg::REG_OFFSET_Y:    sh_off_y    = val[15:0];
            cpup_pkg::REG_PLANE_DEPTH: sh_depth    = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_camera(input logic [15:0] cx, input logic [15:0] cy,
                               input logic [15:0] f, input logic [19:0] k1,
                               input logic [19:0] k2, input logic [15:0] ox,
                               input logic [15:0] oy, input logic [15:0] depth);
        write_reg(cpup_pkg::REG_CENTER_X, {4'd0, cx});
        write_reg(cpup_pkg::REG_CENTER_Y, {4'd0, cy});
        write_reg(cpup_pkg::REG_FOCAL_LEN, {4'd0, f});
        write_reg(cpup_pkg::REG_RADIAL_K1, k1);
        write_reg(cpup_pkg::REG_RADIAL_K2, k2);
        write_reg(cpup_pkg::REG_OFFSET_X, {4'd0, ox});
        write_reg(cpup_pkg::REG_OFFSET_Y, {4'd0, oy});
        write_reg(cpup_pkg::REG_PLANE_DEPTH, {4'd0, depth});
        cfg_valid <= 1'b0;
    endtask

    // Offer one pixel pair, optionally after a random idle gap, and record
    // the expected world position once the transaction is accepted. Valid
    // stays up afterwards so that items can follow back to back.
    task automatic send_pixel(input logic [8:0] px, input logic [8:0] py);
        cpup_pkg::cpup_in_t pix;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        pix.pixel_x = px;
        pix.pixel_y = py;
        in_data  <= pix;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_world.push_back(project_pixel(pix));
        @(negedge clk);
    endtask

    // Wait until every expected result has come back, then let the pipeline
    // drain fully before configuration may change.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_world.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_pixel(9'($urandom_range(511)), 9'($urandom_range(511)));
    endtask

    // Receiver: stalls at random, or for a long stretch when asked.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_recv)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        cpup_pkg::cpup_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_world.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", out_data);
            end
            else
            begin
                want = pending_world.pop_front();
                if (want.world_x !== out_data.world_x || want.world_y !== out_data.world_y ||
                    want.out_of_range !== out_data.out_of_range)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected x=%0d y=%0d oor=%b, got x=%0d y=%0d oor=%b",
                                 want.world_x, want.world_y, want.out_of_range,
                                 out_data.world_x, out_data.world_y, out_data.out_of_range);
                end
            end
        end
    end

    // Reset values with a handful of pixels, including the extremes.
    task automatic test_reset_values;
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd0, 9'd511);
        drain();
    endtask

    // A plain camera, the zero and maximal register values, a zero focal
    // length, a negative divisor, a large radius and saturation.
    task automatic test_directed;
        load_camera(16'd8192, 16'd8192, 16'd4096, 20'sd6554, -20'sd655, 16'sd100,
                    -16'sd100, 16'd20000);
        send_pixel(9'd256, 9'd256);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd0);
        send_pixel(9'h155, 9'h0AA);
        send_pixel(9'h0AA, 9'h155);
        drain();
        // Zero focal length: nothing to divide by.
        load_camera(16'd0, 16'd65535, 16'd0, 20'h7FFFF, 20'h80000, 16'h7FFF, 16'h8000,
                    16'hFFFF);
        send_pixel(9'd100, 9'd200);
        drain();
        // Strongly negative k1 drives the divisor below zero.
        load_camera(16'd0, 16'd0, 16'd16, 20'h80000, 20'h80000, 16'h8000, 16'h7FFF,
                    16'd64);
        send_pixel(9'd1, 9'd1);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd0, 9'd0);
        drain();
        // Tiny focal length: radius cap and saturation of the world result.
        load_camera(16'd65535, 16'd0, 16'd16, 20'd0, 20'd0, 16'd0, 16'd0, 16'hFFFF);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd2, 9'd3);
        drain();
        // Widest focal length and positive maximal coefficients.
        load_camera(16'd0, 16'd0, 16'hFFFF, 20'h7FFFF, 20'h7FFFF, 16'h7FFF, 16'h7FFF,
                    16'hFFFF);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd300, 9'd17);
        drain();
    endtask

    // Random pixels under a fresh random camera per phase.
    task automatic test_random_camera(input int phases, input int per_phase);
        repeat (phases)
        begin
            load_camera(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                        16'($urandom_range(8000, 16)), 20'($urandom_range(20'hFFFFF)),
                        20'($urandom_range(20'hFFFFF)), 16'($urandom_range(65535)),
                        16'($urandom_range(65535)), 16'($urandom_range(65535)));
            send_random(per_phase);
            drain();
        end
    endtask

    // Realistic camera: centre near the image middle, mild distortion.
    task automatic test_typical_camera(input int count);
        load_camera(16'(8192 + $urandom_range(400)), 16'(8192 - $urandom_range(400)),
                    16'(6000 + $urandom_range(2000)), 20'(3000 + $urandom_range(3000)),
                    -20'sd500, 16'sd320, -16'sd640, 16'd25600);
        send_random(count);
        drain();
    endtask

    // Hold the receiver off for a long stretch while items keep coming, so
    // the pipeline fills and the input stalls.
    task automatic test_back_pressure;
        hold_recv = 1'b1;
        fork
            begin
                hold_cycles = 0;
                while (hold_cycles < 300)
                begin
                    @(negedge clk);
                    hold_cycles++;
                end
                hold_recv = 1'b0;
            end
            send_random(150);
        join
        drain();
    endtask

    initial
    begin
        errors = 0;
        hold_recv = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sh_center_x = 16'd0;
        sh_center_y = 16'd0;
        sh_focal = cpup_pkg::FOCAL_RESET;
        sh_k1 = '0;
        sh_k2 = '0;
        sh_off_x = '0;
        sh_off_y = '0;
        sh_depth = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_values();
        test_directed();

        send_idle_pct = 18;
        recv_idle_pct = 82;
        test_random_camera(4, 80);
        test_typical_camera(250);

        send_idle_pct = 82;
        recv_idle_pct = 18;
        test_random_camera(4, 80);
        test_typical_camera(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_back_pressure();
        test_random_camera(4, 80);
        test_typical_camera(260);

        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: camera_point_undistort_to_plane.f
+incdir+rtl
rtl/cpup_pkg.sv
rtl/cpup_div.sv
rtl/cpup_dly.sv
rtl/camera_point_undistort_to_plane.sv
rtl/cpup_chk.sv
verif/tb.sv
